FILE: src/adcsm_pkg.sv
package adcsm_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int SAMPLE_W    = 24;

    localparam logic [7:0]  HALF_PERIOD_RST   = 8'd48;
    localparam logic [15:0] READ_TIMEOUT_RST  = 16'd100;
    localparam logic [15:0] WRITE_TIMEOUT_RST = 16'd500;

    localparam logic [6:0] WRITE_CMD        = 7'h65;
    localparam logic [5:0] WRITE_LAST_CLOCK = 6'd46;
    localparam logic [5:0] READ_LAST_CLOCK  = 6'(SAMPLE_BITS + 3);
    localparam logic [5:0] SAMPLE_CLOCKS    = 6'(SAMPLE_BITS);
    localparam logic [5:0] DRIVE_FIRST      = 6'd28;
    localparam logic [5:0] CMD_FIRST        = 6'd30;
    localparam logic [5:0] CMD_LAST         = 6'd36;
    localparam logic [5:0] SET_FIRST        = 6'd38;
    localparam logic [5:0] SET_LAST         = 6'd45;

    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    localparam logic [1:0] REG_HALF_PERIOD   = 2'd0;
    localparam logic [1:0] REG_READ_TIMEOUT  = 2'd1;
    localparam logic [1:0] REG_WRITE_TIMEOUT = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_WAIT  = 5'b00010,
        PH_SETUP = 5'b00100,
        PH_HIGH  = 5'b01000,
        PH_LOW   = 5'b10000
    } phase_t;

    function automatic logic needs_setup(input logic [5:0] c);
        return (c >= CMD_FIRST && c <= CMD_LAST) || (c >= SET_FIRST && c <= SET_LAST);
    endfunction

    function automatic logic write_level(input logic [5:0] c, input logic [6:0] held);
        logic [5:0] idx;
        logic [7:0] setting;
        setting = {1'b0, held};
        if (c >= CMD_FIRST && c <= CMD_LAST) begin
            idx = CMD_LAST - c;
            return WRITE_CMD[idx[2:0]];
        end else if (c >= SET_FIRST && c <= SET_LAST) begin
            idx = SET_LAST - c;
            return setting[idx[2:0]];
        end
        return 1'b1;
    endfunction

endpackage

FILE: src/adc_two_wire_serial_master_top.sv
// Two-wire serial master for a 24-bit delta-sigma converter. Every input beat is one
// clock tick of the serial sequencer and yields exactly one result beat with the pin
// levels and status for that tick; one beat is taken per cycle unless the output
// stalls, set by the single registered next-state step and the result register. kind 1
// starts a sample read, kind 2 a setting write; both wait for the data line to go low,
// counting ms_pulse beats against the read or write timeout. Reads shift in 24 bits
// MSB first and give three extra pulses; writes clock 27 released pulses, then drive
// the 0x65 command and the setting. Registers (APB): 0x0 half period ticks, 0x4 read
// timeout ms, 0x8 write timeout ms; write them only while the block is idle.
module adc_two_wire_serial_master_top (
    input  logic        aclk,
    input  logic        aresetn,
    // tdata: setting_value[6:0], line_level[7], ms_pulse[8], zero fill
    input  logic [15:0] s_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]  s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tdata: sclk[0], line_drive[1], line_out[2], sample[26:3], busy_res[27],
    //        data_ready[28], zero fill
    output logic [31:0] m_tdata,
    // tuser: sample_valid[0], write_done[1], timed_out[2]
    output logic [2:0]  m_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import adcsm_pkg::*;

    logic [7:0]  half_period_reg;
    logic [15:0] read_timeout_reg;
    logic [15:0] write_timeout_reg;

    phase_t      phase_reg, phase_next;
    logic [5:0]  clock_count_reg, clock_count_next;
    logic [7:0]  half_tick_reg, half_tick_next;
    logic [15:0] wait_ms_reg, wait_ms_next;
    logic [23:0] shift_reg, shift_next;
    logic [6:0]  held_setting_reg, held_setting_next;
    logic        is_write_reg, is_write_next;

    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg, m_tdata_next;
    logic [2:0]  m_tuser_reg, m_tuser_next;

    logic [1:0]  kind;
    logic [6:0]  setv;
    logic        line;
    logic        msp;
    logic        s_fire;
    logic        cfg_wr;

    logic        half_end;
    logic [5:0]  last_clock;
    logic [16:0] wait_sum;
    logic [15:0] wait_cnt;
    logic [15:0] limit;
    logic [5:0]  clock_inc;
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic        o_sclk, o_drive, o_lout, o_valid, o_done, o_tout, o_busy;
    logic [SAMPLE_W-1:0] o_sample;

    assign kind   = s_tuser;
    assign setv   = s_tdata[6:0];
    assign line   = s_tdata[7];
    assign msp    = s_tdata[8];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[3:2])
            REG_HALF_PERIOD:   prdata = {24'd0, half_period_reg};
            REG_READ_TIMEOUT:  prdata = {16'd0, read_timeout_reg};
            REG_WRITE_TIMEOUT: prdata = {16'd0, write_timeout_reg};
            default:           prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_period_reg   <= HALF_PERIOD_RST;
            read_timeout_reg  <= READ_TIMEOUT_RST;
            write_timeout_reg <= WRITE_TIMEOUT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_HALF_PERIOD:   half_period_reg   <= pwdata[7:0];
                REG_READ_TIMEOUT:  read_timeout_reg  <= pwdata[15:0];
                REG_WRITE_TIMEOUT: write_timeout_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign half_end   = ({1'b0, half_tick_reg} + 9'd1) >= {1'b0, half_period_reg};
    assign last_clock = is_write_reg ? WRITE_LAST_CLOCK : READ_LAST_CLOCK;
    assign wait_sum   = {1'b0, wait_ms_reg} + {16'd0, msp};
    assign wait_cnt   = wait_sum[16] ? 16'hFFFF : wait_sum[15:0];
    assign limit      = is_write_reg ? write_timeout_reg : read_timeout_reg;
    assign clock_inc  = clock_count_reg + 6'd1;
    assign raw_sample = shift_reg[SAMPLE_BITS-1:0];

    always_comb begin
        phase_next        = phase_reg;
        clock_count_next  = clock_count_reg;
        half_tick_next    = half_tick_reg;
        wait_ms_next      = wait_ms_reg;
        shift_next        = shift_reg;
        held_setting_next = held_setting_reg;
        is_write_next     = is_write_reg;
        o_sclk   = 1'b0;
        o_drive  = 1'b0;
        o_lout   = 1'b0;
        o_valid  = 1'b0;
        o_done   = 1'b0;
        o_tout   = 1'b0;
        o_sample = '0;

        if ((phase_reg == PH_SETUP || phase_reg == PH_HIGH || phase_reg == PH_LOW) &&
            is_write_reg && clock_count_reg >= DRIVE_FIRST) begin
            o_drive = 1'b1;
            o_lout  = write_level(clock_count_reg, held_setting_reg);
        end

        unique case (phase_reg)
            PH_IDLE: begin
                if (kind == KIND_READ || kind == KIND_WRITE) begin
                    is_write_next     = (kind == KIND_WRITE);
                    held_setting_next = setv;
                    wait_ms_next      = 16'd0;
                    clock_count_next  = 6'd0;
                    half_tick_next    = 8'd0;
                    shift_next        = 24'd0;
                    phase_next        = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (!line) begin
                    clock_count_next = 6'd1;
                    half_tick_next   = 8'd0;
                    phase_next       = PH_HIGH;
                end else if (wait_cnt >= limit) begin
                    o_tout     = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    wait_ms_next = wait_cnt;
                end
            end
            PH_SETUP: begin
                if (half_end) begin
                    half_tick_next = 8'd0;
                    phase_next     = PH_HIGH;
                end else begin
                    half_tick_next = half_tick_reg + 8'd1;
                end
            end
            PH_HIGH: begin
                o_sclk = 1'b1;
                if (half_end) begin
                    if (!is_write_reg && clock_count_reg <= SAMPLE_CLOCKS) begin
                        shift_next = {shift_reg[22:0], line};
                    end
                    half_tick_next = 8'd0;
                    phase_next     = PH_LOW;
                end else begin
                    half_tick_next = half_tick_reg + 8'd1;
                end
            end
            PH_LOW: begin
                if (half_end) begin
                    half_tick_next = 8'd0;
                    if (clock_count_reg >= last_clock) begin
                        if (is_write_reg) begin
                            o_done = 1'b1;
                        end else begin
                            o_valid  = 1'b1;
                            o_sample = SAMPLE_W'($signed(raw_sample));
                        end
                        phase_next = PH_IDLE;
                    end else begin
                        clock_count_next = clock_inc;
                        phase_next = (is_write_reg && needs_setup(clock_inc)) ?
                                     PH_SETUP : PH_HIGH;
                    end
                end else begin
                    half_tick_next = half_tick_reg + 8'd1;
                end
            end
            default: phase_next = PH_IDLE;
        endcase

        o_busy       = (phase_next != PH_IDLE);
        m_tdata_next = {3'd0, !line, o_busy, o_sample, o_lout, o_drive, o_sclk};
        m_tuser_next = {o_tout, o_done, o_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            clock_count_reg  <= 6'd0;
            half_tick_reg    <= 8'd0;
            wait_ms_reg      <= 16'd0;
            shift_reg        <= 24'd0;
            held_setting_reg <= 7'd0;
            is_write_reg     <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (s_fire) begin
                phase_reg        <= phase_next;
                clock_count_reg  <= clock_count_next;
                half_tick_reg    <= half_tick_next;
                wait_ms_reg      <= wait_ms_next;
                shift_reg        <= shift_next;
                held_setting_reg <= held_setting_next;
                is_write_reg     <= is_write_next;
                m_tvalid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    a_finish_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser[0] || m_tuser[1] || m_tuser[2]) |-> !m_tdata[27])
        else $error("busy flag set on a finishing beat");

    a_one_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones(m_tuser) <= 1)
        else $error("more than one completion flag in a beat");

    a_timeout_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> !m_tdata[0] && !m_tdata[1])
        else $error("serial clock or drive active on a timeout beat");

    a_out_needs_drive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[2] |-> m_tdata[1])
        else $error("line level driven without drive enable");

    a_start_arms_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && phase_reg == PH_IDLE && (kind == KIND_READ || kind == KIND_WRITE)
        |=> phase_reg == PH_WAIT)
        else $error("start beat did not arm the wait");

endmodule

FILE: bench/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import adcsm_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int END_PAD_CYCLES = 16;
    localparam int RANDOM_PHASE_TICKS = 60;
    localparam int RANDOM_PHASES = 4;

    typedef struct packed {
        logic                sclk;
        logic                drive;
        logic                lout;
        logic [SAMPLE_W-1:0] sample;
        logic                valid;
        logic                done;
        logic                tout;
        logic                busy;
        logic                ready;
    } tick_levels_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // sequencer state as predicted
    phase_t              ph;
    logic [5:0]          clk_num;
    logic [7:0]          half_cnt;
    logic [15:0]         wait_ms;
    logic [SAMPLE_W-1:0] shreg;
    logic [6:0]          held;
    logic                wr;
    logic [7:0]          half_ticks;
    logic [15:0]         rd_limit;
    logic [15:0]         wr_limit;

    tick_levels_t tick_levels_due[$];
    int           fails;
    int           ticks_sent;
    int           n_samples;
    int           n_writes;
    int           n_timeouts;
    int           n_settings;
    logic         steady_tx;
    logic         rx_hold_go;

    adc_two_wire_serial_master_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    task automatic advance_sequencer(input logic [1:0] kind, input logic [6:0] setv,
                                     input logic line, input logic msp,
                                     output tick_levels_t r);
        logic        half_end;
        logic [16:0] cnt;
        logic [15:0] limit;
        logic [5:0]  end_clock;
        logic [18:0] frame;
        logic [4:0]  fidx;
        r = '0;
        end_clock = wr ? WRITE_LAST_CLOCK : READ_LAST_CLOCK;
        half_end = ({1'b0, half_cnt} + 9'd1) >= {1'b0, half_ticks};
        // line levels for clocks 28 up to 46, clock 28 in the top bit
        frame = {2'b11, WRITE_CMD, 1'b1, 1'b0, held, 1'b1};
        if ((ph == PH_SETUP || ph == PH_HIGH || ph == PH_LOW) && wr
                && clk_num >= DRIVE_FIRST) begin
            fidx = 5'(WRITE_LAST_CLOCK - clk_num);
            r.drive = 1'b1;
            r.lout = frame[fidx];
        end
        case (ph)
            PH_IDLE: begin
                if (kind == KIND_READ || kind == KIND_WRITE) begin
                    wr = (kind == KIND_WRITE);
                    held = setv;
                    wait_ms = '0;
                    clk_num = '0;
                    half_cnt = '0;
                    shreg = '0;
                    ph = PH_WAIT;
                end
            end
            PH_WAIT: begin
                cnt = {1'b0, wait_ms} + {16'd0, msp};
                if (cnt > 17'hFFFF) cnt = 17'hFFFF;
                limit = wr ? wr_limit : rd_limit;
                if (!line) begin
                    clk_num = 6'd1;
                    half_cnt = '0;
                    ph = PH_HIGH;
                end else if (cnt >= {1'b0, limit}) begin
                    r.tout = 1'b1;
                    ph = PH_IDLE;
                end else begin
                    wait_ms = cnt[15:0];
                end
            end
            PH_SETUP: begin
                if (half_end) begin
                    half_cnt = '0;
                    ph = PH_HIGH;
                end else begin
                    half_cnt = half_cnt + 8'd1;
                end
            end
            PH_HIGH: begin
                r.sclk = 1'b1;
                if (half_end) begin
                    if (!wr && clk_num <= SAMPLE_CLOCKS) shreg = {shreg[SAMPLE_W-2:0], line};
                    half_cnt = '0;
                    ph = PH_LOW;
                end else begin
                    half_cnt = half_cnt + 8'd1;
                end
            end
            PH_LOW: begin
                if (half_end) begin
                    half_cnt = '0;
                    if (clk_num >= end_clock) begin
                        if (wr) begin
                            r.done = 1'b1;
                        end else begin
                            r.valid = 1'b1;
                            r.sample = SAMPLE_W'($signed(shreg[SAMPLE_BITS-1:0]));
                        end
                        ph = PH_IDLE;
                    end else begin
                        clk_num = clk_num + 6'd1;
                        if (wr && ((clk_num >= CMD_FIRST && clk_num <= CMD_LAST)
                                || (clk_num >= SET_FIRST && clk_num <= SET_LAST)))
                            ph = PH_SETUP;
                        else
                            ph = PH_HIGH;
                    end
                end else begin
                    half_cnt = half_cnt + 8'd1;
                end
            end
            default: ph = PH_IDLE;
        endcase
        r.busy = (ph != PH_IDLE);
        r.ready = !line;
    endtask

    task automatic offer_tick(input logic [1:0] kind, input logic [6:0] setv,
                              input logic line, input logic msp);
        tick_levels_t r;
        int           pick;
        int           gap;
        pick = $urandom_range(0, 99);
        gap = 0;
        if (!steady_tx && pick >= 65)
            gap = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {7'b0, msp, line, setv};
        do @(posedge aclk); while (!s_tready);
        advance_sequencer(kind, setv, line, msp, r);
        tick_levels_due.push_back(r);
        ticks_sent++;
    endtask

    // start one transfer and tick until the sequencer is back to idle
    task automatic run_transfer(input logic [1:0] kind, input logic [6:0] setv,
                                input logic [SAMPLE_W-1:0] data, input int ready_after,
                                input int ms_rate, input logic noisy);
        int         waited;
        logic       line;
        logic [1:0] k;
        logic [4:0] bit_idx;
        waited = 0;
        offer_tick(kind, setv, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        while (ph != PH_IDLE) begin
            k = noisy ? 2'($urandom_range(0, 3)) : KIND_TICK;
            if (ph == PH_WAIT) begin
                line = (waited >= ready_after) ? 1'b0 : 1'b1;
                waited++;
            end else if (ph == PH_HIGH && !wr && clk_num >= 1 && clk_num <= SAMPLE_CLOCKS) begin
                bit_idx = 5'(SAMPLE_BITS - int'(clk_num));
                line = data[bit_idx];
            end else begin
                line = 1'($urandom_range(0, 1));
            end
            offer_tick(k, 7'($urandom), line, $urandom_range(0, 99) < ms_rate);
        end
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tick_levels_due.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input logic [1:0] idx, input logic is_wr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_wr;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (!is_wr && prdata !== val) begin
            $error("register %0d: expected 0x%0h actual 0x%0h", idx, val, prdata);
            fails++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [7:0] hp, input logic [15:0] rto,
                              input logic [15:0] wto);
        drain_results();
        apb_access(REG_HALF_PERIOD, 1'b1, {24'b0, hp});
        half_ticks = hp;
        apb_access(REG_READ_TIMEOUT, 1'b1, {16'b0, rto});
        rd_limit = rto;
        apb_access(REG_WRITE_TIMEOUT, 1'b1, {16'b0, wto});
        wr_limit = wto;
        apb_access(REG_HALF_PERIOD, 1'b0, {24'b0, half_ticks});
        apb_access(REG_READ_TIMEOUT, 1'b0, {16'b0, rd_limit});
        apb_access(REG_WRITE_TIMEOUT, 1'b0, {16'b0, wr_limit});
        n_settings++;
    endtask

    task automatic random_transfer();
        int                  pick;
        int                  ready_after;
        logic [SAMPLE_W-1:0] data;
        pick = $urandom_range(0, 99);
        data = SAMPLE_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
                0: data = '1;
                1: data = {1'b1, {(SAMPLE_W-1){1'b0}}};
                2: data = {1'b0, {(SAMPLE_W-1){1'b1}}};
                default: data = '0;
            endcase
        end
        ready_after = $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0) ready_after = 10000;
        else if ($urandom_range(0, 6) == 0) ready_after = $urandom_range(4, 12);
        steady_tx = ($urandom_range(0, 4) == 0);
        if (pick < 40) begin
            run_transfer(KIND_READ, 7'($urandom), data, ready_after,
                         $urandom_range(10, 60), 1'($urandom_range(0, 1)));
        end else if (pick < 80) begin
            run_transfer(KIND_WRITE, 7'($urandom), data, ready_after,
                         $urandom_range(10, 60), 1'($urandom_range(0, 1)));
        end else begin
            repeat ($urandom_range(1, 5))
                offer_tick($urandom_range(0, 1) ? KIND_SPARE : KIND_TICK, 7'($urandom),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
        steady_tx = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h actual 0x%0h", name, want, got);
            fails++;
        end
    endtask

    always @(posedge aclk) begin : check_tick_levels
        tick_levels_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (tick_levels_due.size() == 0) begin
                $error("result beat with nothing expected");
                fails++;
            end else begin
                want = tick_levels_due.pop_front();
                check_field("sclk", SAMPLE_W'(want.sclk), SAMPLE_W'(m_tdata[0]));
                check_field("line_drive", SAMPLE_W'(want.drive), SAMPLE_W'(m_tdata[1]));
                check_field("line_out", SAMPLE_W'(want.lout), SAMPLE_W'(m_tdata[2]));
                check_field("sample", want.sample, m_tdata[26:3]);
                check_field("busy_res", SAMPLE_W'(want.busy), SAMPLE_W'(m_tdata[27]));
                check_field("data_ready", SAMPLE_W'(want.ready), SAMPLE_W'(m_tdata[28]));
                check_field("sample_valid", SAMPLE_W'(want.valid), SAMPLE_W'(m_tuser[0]));
                check_field("write_done", SAMPLE_W'(want.done), SAMPLE_W'(m_tuser[1]));
                check_field("timed_out", SAMPLE_W'(want.tout), SAMPLE_W'(m_tuser[2]));
                if (want.valid) n_samples++;
                if (want.done) n_writes++;
                if (want.tout) n_timeouts++;
            end
        end
    end

    initial begin : result_sink
        forever begin
            if (rx_hold_go) begin
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge aclk);
                rx_hold_go = 1'b0;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:54]: begin
                        m_tready <= 1'b1;
                        repeat ($urandom_range(1, 12)) @(posedge aclk);
                    end
                    [55:61]: begin
                        m_tready <= 1'b1;
                        repeat ($urandom_range(100, 300)) @(posedge aclk);
                    end
                    [62:94]: begin
                        m_tready <= 1'b0;
                        repeat ($urandom_range(1, 3)) @(posedge aclk);
                    end
                    default: begin
                        m_tready <= 1'b0;
                        repeat ($urandom_range(8, 40)) @(posedge aclk);
                    end
                endcase
            end
        end
    end

    task automatic test_basic_transfers();
        set_config(8'd1, 16'd3, 16'd2);
        offer_tick(KIND_TICK, 7'h7F, 1'b1, 1'b1);
        offer_tick(KIND_SPARE, 7'h00, 1'b0, 1'b0);
        run_transfer(KIND_READ, 7'h00, 24'hFFFFFF, 0, 0, 1'b0);
        run_transfer(KIND_READ, 7'h7F, 24'h800000, 1, 0, 1'b0);
        run_transfer(KIND_READ, 7'h00, 24'h7FFFFF, 2, 50, 1'b0);
        run_transfer(KIND_READ, 7'h00, 24'h000000, 0, 0, 1'b0);
        run_transfer(KIND_READ, 7'h00, 24'h000000, 10000, 100, 1'b0);
        run_transfer(KIND_WRITE, 7'h7F, 24'h0, 0, 0, 1'b0);
        run_transfer(KIND_WRITE, 7'h00, 24'h0, 1, 0, 1'b0);
        run_transfer(KIND_WRITE, 7'h2A, 24'h0, 10000, 100, 1'b0);
        run_transfer(KIND_READ, 7'h55, 24'hA5C3E1, 1, 30, 1'b1);
        run_transfer(KIND_WRITE, 7'h55, 24'h0, 1, 30, 1'b1);
    endtask

    task automatic test_config_extremes();
        set_config(8'd0, 16'd0, 16'd0);
        run_transfer(KIND_READ, 7'h00, 24'h123456, 0, 50, 1'b0);
        run_transfer(KIND_READ, 7'h00, 24'h0, 1, 0, 1'b0);
        run_transfer(KIND_WRITE, 7'h41, 24'h0, 0, 50, 1'b0);
        run_transfer(KIND_WRITE, 7'h41, 24'h0, 1, 0, 1'b0);
        steady_tx = 1'b1;
        set_config(8'd2, 16'hFFFF, 16'hFFFF);
        run_transfer(KIND_READ, 7'h00, 24'h800000, 3, 50, 1'b0);
        run_transfer(KIND_WRITE, 7'h55, 24'h0, 2, 50, 1'b1);
        steady_tx = 1'b0;
    endtask

    task automatic test_full_backpressure();
        set_config(8'd2, 16'd4, 16'd4);
        rx_hold_go = 1'b1;
        while (rx_hold_go) random_transfer();
    endtask

    task automatic test_random_transfers();
        int start;
        repeat (RANDOM_PHASES) begin
            if ($urandom_range(0, 9) == 0)
                set_config(8'($urandom_range(5, 16)), 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 8)));
            else
                set_config(8'($urandom_range(0, 3)), 16'($urandom_range(0, 8)),
                           16'($urandom_range(0, 8)));
            start = ticks_sent;
            while (ticks_sent - start < RANDOM_PHASE_TICKS) random_transfer();
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= KIND_TICK;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        fails = 0;
        ticks_sent = 0;
        n_samples = 0;
        n_writes = 0;
        n_timeouts = 0;
        n_settings = 0;
        steady_tx = 1'b0;
        rx_hold_go = 1'b0;
        ph = PH_IDLE;
        clk_num = '0;
        half_cnt = '0;
        wait_ms = '0;
        shreg = '0;
        held = '0;
        wr = 1'b0;
        half_ticks = HALF_PERIOD_RST;
        rd_limit = READ_TIMEOUT_RST;
        wr_limit = WRITE_TIMEOUT_RST;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_basic_transfers();
        test_config_extremes();
        test_full_backpressure();
        test_random_transfers();

        drain_results();
        repeat (END_PAD_CYCLES) @(posedge aclk);
        if (tick_levels_due.size() != 0) begin
            $error("%0d result beats never arrived", tick_levels_due.size());
            fails++;
        end
        $display("%0d ticks checked across %0d register settings", ticks_sent, n_settings);
        $display("%0d samples read, %0d setting writes, %0d waits timed out",
                 n_samples, n_writes, n_timeouts);
        if (fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
